/* rtl/core/skt_pkg.sv */
// Package for the session key expiry table: constants, types and codes.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none
package skt_pkg;
    localparam int ENTRIES_DEF = 64;

    localparam logic [31:0] DEF_KEY0_RST     = 32'h12345678;
    localparam logic [31:0] DEF_KEY1_RST     = 32'h734a67fc;
    localparam logic [31:0] DEF_KEY2_RST     = 32'h3367a642;
    localparam logic [31:0] DEF_KEY3_RST     = 32'h78432562;
    localparam logic [31:0] REKEY_AGE_RST    = 32'd1800;
    localparam logic [31:0] SWEEP_INT_RST    = 32'd7200;
    localparam logic [31:0] EXPIRE_AGE_RST   = 32'd43200;

    localparam logic [2:0] REG_DKEY0  = 3'd0;
    localparam logic [2:0] REG_DKEY1  = 3'd1;
    localparam logic [2:0] REG_DKEY2  = 3'd2;
    localparam logic [2:0] REG_DKEY3  = 3'd3;
    localparam logic [2:0] REG_REKEY  = 3'd4;
    localparam logic [2:0] REG_SWEEP  = 3'd5;
    localparam logic [2:0] REG_EXPIRE = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_STORE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SWEEP,
        S_WRITE,
        S_KEYRD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [127:0] dkey;
        logic [31:0]  rekey_age;
        logic [31:0]  sweep_int;
        logic [31:0]  expire_age;
    } cfg_t;
endpackage
`default_nettype wire

/* rtl/core/skt_regs.sv */
// APB register file of the session key expiry table.
// Depends on skt_pkg.
`default_nettype none
module skt_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output skt_pkg::cfg_t     cfg
);
    logic [31:0] dk0_reg, dk1_reg, dk2_reg, dk3_reg, rk_reg, sw_reg, ex_reg;
    logic [2:0]  idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg.dkey       = {dk3_reg, dk2_reg, dk1_reg, dk0_reg};
    assign cfg.rekey_age  = rk_reg;
    assign cfg.sweep_int  = sw_reg;
    assign cfg.expire_age = ex_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dk0_reg <= skt_pkg::DEF_KEY0_RST;
            dk1_reg <= skt_pkg::DEF_KEY1_RST;
            dk2_reg <= skt_pkg::DEF_KEY2_RST;
            dk3_reg <= skt_pkg::DEF_KEY3_RST;
            rk_reg  <= skt_pkg::REKEY_AGE_RST;
            sw_reg  <= skt_pkg::SWEEP_INT_RST;
            ex_reg  <= skt_pkg::EXPIRE_AGE_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                skt_pkg::REG_DKEY0:  dk0_reg <= pwdata;
                skt_pkg::REG_DKEY1:  dk1_reg <= pwdata;
                skt_pkg::REG_DKEY2:  dk2_reg <= pwdata;
                skt_pkg::REG_DKEY3:  dk3_reg <= pwdata;
                skt_pkg::REG_REKEY:  rk_reg  <= pwdata;
                skt_pkg::REG_SWEEP:  sw_reg  <= pwdata;
                skt_pkg::REG_EXPIRE: ex_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            skt_pkg::REG_DKEY0:  prdata = dk0_reg;
            skt_pkg::REG_DKEY1:  prdata = dk1_reg;
            skt_pkg::REG_DKEY2:  prdata = dk2_reg;
            skt_pkg::REG_DKEY3:  prdata = dk3_reg;
            skt_pkg::REG_REKEY:  prdata = rk_reg;
            skt_pkg::REG_SWEEP:  prdata = sw_reg;
            skt_pkg::REG_EXPIRE: prdata = ex_reg;
            default:             prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/core/session_key_expiry_table.sv */
// Session key expiry table, top level: handshake, scan sequencer, memories.
// Depends on skt_pkg and skt_regs.
// An item is accepted in idle when the output register is empty or is read in the same
// cycle. After the scan, a lookup miss or session-zero item goes straight to the output;
// an update (also a full table) first passes the write state, a lookup hit the key read,
// and a new session that triggers an expiry sweep a second full scan, then the write.
// Each scan reads the session/stamp memory one entry per cycle, the read registered.
// Valid bits sit in flip-flops cleared by reset; no clearing pass is needed.
`default_nettype none
module session_key_expiry_table #(
    parameter int ENTRIES = skt_pkg::ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [31:0] session_id,
    input  wire logic [31:0] now,
    input  wire logic [31:0] new_key_0,
    input  wire logic [31:0] new_key_1,
    input  wire logic [31:0] new_key_2,
    input  wire logic [31:0] new_key_3,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      key_0,
    output logic [31:0]      key_1,
    output logic [31:0]      key_2,
    output logic [31:0]      key_3,
    output logic             used_default,
    output logic             need_rekey,
    output logic [1:0]       status
);
    localparam int AW = $clog2(ENTRIES);

    skt_pkg::cfg_t cfg;

    skt_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    logic [63:0]  meta_mem [ENTRIES];
    logic [127:0] key_mem  [ENTRIES];
    logic [63:0]  meta_rd;
    logic [127:0] key_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          meta_we, key_we;
    logic [63:0]   meta_wd;
    logic [127:0]  key_wd;

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[wr_addr] <= meta_wd;
        if (key_we)
            key_mem[wr_addr] <= key_wd;
        meta_rd <= meta_mem[rd_addr];
        key_rd  <= key_mem[rd_addr];
    end

    logic [ENTRIES-1:0] valid_reg, valid_next;
    skt_pkg::state_t    state_reg, state_next;
    logic [AW:0]        cnt_reg, cnt_next;
    logic               rd_live_reg, rd_live_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic               hit_reg, hit_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [31:0]        stamp_reg, stamp_next;
    logic [31:0]        last_sweep_reg, last_sweep_next;
    logic               act_reg;
    logic [31:0]        sid_reg, now_reg;
    logic [127:0]       nk_reg;
    logic               ov_reg, ov_next;
    logic [127:0]       okey_reg, okey_next;
    logic               oud_reg, oud_next, onr_reg, onr_next;
    logic [1:0]         ost_reg, ost_next;
    logic               free_found;
    logic [AW-1:0]      free_idx;

    assign in_ready     = (state_reg == skt_pkg::S_IDLE) && (!ov_reg || out_ready);
    assign out_valid    = ov_reg;
    assign key_0        = okey_reg[31:0];
    assign key_1        = okey_reg[63:32];
    assign key_2        = okey_reg[95:64];
    assign key_3        = okey_reg[127:96];
    assign used_default = oud_reg;
    assign need_rekey   = onr_reg;
    assign status       = ost_reg;

    // lowest free slot, registered tree avoided: valid word is narrow enough for priority logic
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg <= action;
            sid_reg <= session_id;
            now_reg <= now;
            nk_reg  <= {new_key_3, new_key_2, new_key_1, new_key_0};
        end
        okey_reg <= okey_next;
        oud_reg  <= oud_next;
        onr_reg  <= onr_next;
        ost_reg  <= ost_next;
        slot_reg <= slot_next;
        stamp_reg <= stamp_next;
        rd_idx_reg <= rd_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= skt_pkg::S_IDLE;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            rd_live_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            last_sweep_reg <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
            rd_live_reg    <= rd_live_next;
            hit_reg        <= hit_next;
            last_sweep_reg <= last_sweep_next;
            ov_reg         <= ov_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        rd_live_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        stamp_next      = stamp_reg;
        last_sweep_next = last_sweep_reg;
        ov_next         = ov_reg;
        okey_next       = okey_reg;
        oud_next        = oud_reg;
        onr_next        = onr_reg;
        ost_next        = ost_reg;
        rd_addr         = cnt_reg[AW-1:0];
        wr_addr         = slot_reg;
        meta_we         = 1'b0;
        key_we          = 1'b0;
        meta_wd         = {stamp_reg, sid_reg};
        key_wd          = nk_reg;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        unique case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = skt_pkg::S_SCAN;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                end
            end
            skt_pkg::S_SCAN:
            begin
                if (rd_live_reg && !hit_reg && valid_reg[rd_idx_reg] && sid_reg != 32'd0
                    && meta_rd[31:0] == sid_reg)
                begin
                    hit_next   = 1'b1;
                    slot_next  = rd_idx_reg;
                    stamp_next = meta_rd[63:32];
                end
                if (cnt_reg != (AW+1)'(ENTRIES))
                begin
                    rd_live_next = 1'b1;
                    rd_idx_next  = cnt_reg[AW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                else if (!rd_live_reg)
                begin
                    // scan drained
                    if (act_reg == skt_pkg::ACT_LOOKUP)
                    begin
                        if (hit_reg)
                            state_next = skt_pkg::S_KEYRD;
                        else
                        begin
                            okey_next  = cfg.dkey;
                            oud_next   = 1'b1;
                            onr_next   = (sid_reg != 32'd0);
                            ost_next   = skt_pkg::ST_OK;
                            state_next = skt_pkg::S_OUT;
                        end
                    end
                    else if (sid_reg == 32'd0)
                    begin
                        okey_next  = '0;
                        oud_next   = 1'b0;
                        onr_next   = 1'b0;
                        ost_next   = skt_pkg::ST_ZERO;
                        state_next = skt_pkg::S_OUT;
                    end
                    else if (hit_reg)
                        state_next = skt_pkg::S_WRITE;
                    else if (now_reg - last_sweep_reg >= cfg.sweep_int)
                    begin
                        last_sweep_next = now_reg;
                        cnt_next        = '0;
                        state_next      = skt_pkg::S_SWEEP;
                    end
                    else
                        state_next = skt_pkg::S_WRITE;
                end
            end
            skt_pkg::S_SWEEP:
            begin
                if (rd_live_reg && valid_reg[rd_idx_reg]
                    && now_reg - meta_rd[63:32] >= cfg.expire_age)
                    valid_next[rd_idx_reg] = 1'b0;
                if (cnt_reg != (AW+1)'(ENTRIES))
                begin
                    rd_live_next = 1'b1;
                    rd_idx_next  = cnt_reg[AW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                else if (!rd_live_reg)
                    state_next = skt_pkg::S_WRITE;
            end
            skt_pkg::S_WRITE:
            begin
                oud_next = 1'b0;
                onr_next = 1'b0;
                if (!hit_reg && !free_found)
                begin
                    okey_next = '0;
                    ost_next  = skt_pkg::ST_FULL;
                end
                else
                begin
                    wr_addr   = hit_reg ? slot_reg : free_idx;
                    meta_wd   = {now_reg, sid_reg};
                    meta_we   = 1'b1;
                    key_we    = 1'b1;
                    valid_next[wr_addr] = 1'b1;
                    okey_next = nk_reg;
                    ost_next  = skt_pkg::ST_OK;
                end
                state_next = skt_pkg::S_OUT;
            end
            skt_pkg::S_KEYRD:
            begin
                rd_addr = slot_reg;
                if (rd_live_reg)
                begin
                    okey_next  = key_rd;
                    oud_next   = 1'b0;
                    onr_next   = (now_reg - stamp_reg >= cfg.rekey_age);
                    ost_next   = skt_pkg::ST_OK;
                    state_next = skt_pkg::S_OUT;
                end
                else
                    rd_live_next = 1'b1;
            end
            skt_pkg::S_OUT:
            begin
                ov_next    = 1'b1;
                state_next = skt_pkg::S_IDLE;
            end
            default: state_next = skt_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* tb/sv/session_key_expiry_table_tb.sv */
// Testbench for session_key_expiry_table: lookups, updates, sweeps and table-full cases,
// checked against an in-bench model of the key table. Depends on skt_pkg and the RTL.
`default_nettype none
module session_key_expiry_table_tb;
    localparam int NSLOT = 64;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_ready;
    logic        action;
    logic [31:0] session_id, now;
    logic [31:0] new_key_0, new_key_1, new_key_2, new_key_3;
    logic        out_valid, out_ready;
    logic [31:0] key_0, key_1, key_2, key_3;
    logic        used_default, need_rekey;
    logic [1:0]  status;

    session_key_expiry_table u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .session_id(session_id), .now(now),
        .new_key_0(new_key_0), .new_key_1(new_key_1),
        .new_key_2(new_key_2), .new_key_3(new_key_3),
        .out_valid(out_valid), .out_ready(out_ready),
        .key_0(key_0), .key_1(key_1), .key_2(key_2), .key_3(key_3),
        .used_default(used_default), .need_rekey(need_rekey), .status(status)
    );

    typedef struct packed {
        logic [127:0] key;
        logic         used_default;
        logic         need_rekey;
        logic [1:0]   status;
    } key_reply_t;

    // model state
    logic [127:0] m_dkey;
    logic [31:0]  m_rekey, m_sweep, m_expire, m_last_sweep;
    logic         m_valid [NSLOT];
    logic [31:0]  m_sid   [NSLOT];
    logic [127:0] m_key   [NSLOT];
    logic [31:0]  m_stamp [NSLOT];

    key_reply_t reply_q[$];
    int  errors = 0;
    int  n_items = 0;
    int  n_replies = 0;
    int  hold_cycles = 0;
    int  stall_mode = 0;
    logic [31:0] clock_now = 0;
    logic [31:0] sid_pool[$];

    always
    begin
        clk = 1'b0; #4;
        clk = 1'b1; #4;
    end

    function automatic key_reply_t predict_reply(logic act, logic [31:0] sid, logic [31:0] t,
                                                 logic [127:0] nk);
        key_reply_t r;
        int slot;
        slot = -1;
        r = '0;
        if (sid != 0)
            for (int i = 0; i < NSLOT; i++)
                if (slot < 0 && m_valid[i] && m_sid[i] == sid)
                    slot = i;
        if (act == skt_pkg::ACT_LOOKUP)
        begin
            if (slot >= 0)
            begin
                r.key = m_key[slot];
                r.need_rekey = (t - m_stamp[slot]) >= m_rekey;
            end
            else
            begin
                r.key = m_dkey;
                r.used_default = 1'b1;
                r.need_rekey = (sid != 0);
            end
        end
        else if (sid == 0)
            r.status = skt_pkg::ST_ZERO;
        else
        begin
            if (slot < 0)
            begin
                if ((t - m_last_sweep) >= m_sweep)
                begin
                    m_last_sweep = t;
                    for (int i = 0; i < NSLOT; i++)
                        if (m_valid[i] && (t - m_stamp[i]) >= m_expire)
                            m_valid[i] = 1'b0;
                end
                for (int i = 0; i < NSLOT; i++)
                    if (slot < 0 && !m_valid[i])
                        slot = i;
            end
            if (slot < 0)
                r.status = skt_pkg::ST_FULL;
            else
            begin
                m_valid[slot] = 1'b1;
                m_sid[slot] = sid;
                m_key[slot] = nk;
                m_stamp[slot] = t;
                r.key = nk;
            end
        end
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            skt_pkg::REG_DKEY0:  m_dkey[31:0]   = val;
            skt_pkg::REG_DKEY1:  m_dkey[63:32]  = val;
            skt_pkg::REG_DKEY2:  m_dkey[95:64]  = val;
            skt_pkg::REG_DKEY3:  m_dkey[127:96] = val;
            skt_pkg::REG_REKEY:  m_rekey  = val;
            skt_pkg::REG_SWEEP:  m_sweep  = val;
            skt_pkg::REG_EXPIRE: m_expire = val;
            default: ;
        endcase
    endtask

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_item(logic act, logic [31:0] sid, logic [31:0] t, logic [127:0] nk);
        in_valid = 1'b1;
        action = act; session_id = sid; now = t;
        {new_key_3, new_key_2, new_key_1, new_key_0} = nk;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        reply_q.push_back(predict_reply(act, sid, t, nk));
        n_items++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        @(negedge clk);
        while (reply_q.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (2 * NSLOT + 20) @(negedge clk);
    endtask

    task automatic burst_gap;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 12)) @(negedge clk);
    endtask

    function automatic logic [127:0] rand_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic test_reset_defaults;
        @(negedge clk);
        send_item(skt_pkg::ACT_LOOKUP, 32'd0, 32'd0, '0);
        send_item(skt_pkg::ACT_LOOKUP, 32'd5, 32'd100, '1);
        send_item(skt_pkg::ACT_STORE, 32'd0, 32'd0, '1);
        drain();
    endtask

    task automatic test_directed;
        @(negedge clk);
        send_item(skt_pkg::ACT_STORE, 32'hFFFF_FFFF, 32'd10, '1);
        send_item(skt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'd10, '0);
        send_item(skt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'd1810, '0);
        send_item(skt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'd1809, '0);
        send_item(skt_pkg::ACT_STORE, 32'd1, 32'hFFFF_FFFF, 128'h0);
        send_item(skt_pkg::ACT_LOOKUP, 32'd1, 32'd5, '0);
        send_item(skt_pkg::ACT_STORE, 32'hFFFF_FFFF, 32'd20, rand_key());
        send_item(skt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'd0, '0);
        // overfill the table by one, then one more new session with no sweep due
        for (int i = 2; i < NSLOT + 1; i++)
            send_item(skt_pkg::ACT_STORE, i, 32'd30, rand_key());
        send_item(skt_pkg::ACT_STORE, 32'd999, 32'd40, rand_key());
        send_item(skt_pkg::ACT_STORE, 32'd999, 32'd7200, rand_key());
        send_item(skt_pkg::ACT_STORE, 32'd998, 32'd50000, rand_key());
        send_item(skt_pkg::ACT_LOOKUP, 32'd2, 32'd50000, '0);
        drain();
    endtask

    task automatic test_config_extremes;
        write_reg(skt_pkg::REG_DKEY0, 32'h0);
        write_reg(skt_pkg::REG_DKEY1, 32'hFFFF_FFFF);
        write_reg(skt_pkg::REG_DKEY2, 32'h0);
        write_reg(skt_pkg::REG_DKEY3, 32'hFFFF_FFFF);
        write_reg(skt_pkg::REG_REKEY, 32'd0);
        write_reg(skt_pkg::REG_SWEEP, 32'd0);
        write_reg(skt_pkg::REG_EXPIRE, 32'd0);
        @(negedge clk);
        send_item(skt_pkg::ACT_LOOKUP, 32'd12345, 32'd1, '0);
        send_item(skt_pkg::ACT_STORE, 32'd77, 32'd1, rand_key());
        send_item(skt_pkg::ACT_LOOKUP, 32'd77, 32'd1, '0);
        send_item(skt_pkg::ACT_STORE, 32'd78, 32'd1, rand_key());
        send_item(skt_pkg::ACT_LOOKUP, 32'd77, 32'd1, '0);
        drain();
        write_reg(skt_pkg::REG_REKEY, 32'hFFFF_FFFF);
        write_reg(skt_pkg::REG_SWEEP, 32'hFFFF_FFFF);
        write_reg(skt_pkg::REG_EXPIRE, 32'hFFFF_FFFF);
        @(negedge clk);
        send_item(skt_pkg::ACT_STORE, 32'd79, 32'd0, rand_key());
        send_item(skt_pkg::ACT_LOOKUP, 32'd78, 32'd0, '0);
        send_item(skt_pkg::ACT_LOOKUP, 32'd79, 32'hFFFF_FFFF, '0);
        drain();
    endtask

    task automatic run_random(int count);
        logic [31:0] sid;
        logic        act;
        for (int n = 0; n < count; n++)
        begin
            burst_gap();
            if ($urandom_range(0, 19) == 0)
                sid = $urandom;
            else if ($urandom_range(0, 29) == 0)
                sid = 0;
            else if (sid_pool.size() == 0 || $urandom_range(0, 5) == 0)
            begin
                sid = $urandom_range(1, 200);
                sid_pool.push_back(sid);
                if (sid_pool.size() > 90) void'(sid_pool.pop_front());
            end
            else
                sid = sid_pool[$urandom_range(0, sid_pool.size() - 1)];
            act = ($urandom_range(0, 1) == 1) ? skt_pkg::ACT_STORE : skt_pkg::ACT_LOOKUP;
            clock_now = clock_now + ($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 900));
            send_item(act, sid, clock_now, rand_key());
        end
        drain();
    endtask

    task automatic test_random_settings;
        for (int p = 0; p < 4; p++)
        begin
            write_reg(skt_pkg::REG_DKEY0, $urandom);
            write_reg(skt_pkg::REG_DKEY1, $urandom);
            write_reg(skt_pkg::REG_DKEY2, $urandom);
            write_reg(skt_pkg::REG_DKEY3, $urandom);
            write_reg(skt_pkg::REG_REKEY, $urandom_range(0, 3000));
            write_reg(skt_pkg::REG_SWEEP, $urandom_range(0, 9000));
            write_reg(skt_pkg::REG_EXPIRE, $urandom_range(500, 20000));
            stall_mode = p;
            if (p == 1)
                hold_cycles = 3000;
            run_random(420);
        end
    endtask

    // result checker with stall pattern
    always @(posedge clk)
    begin
        key_reply_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (reply_q.size() == 0)
            begin
                $error("result with no expectation pending");
                errors++;
            end
            else
            begin
                exp_r = reply_q.pop_front();
                n_replies++;
                if (key_0 !== exp_r.key[31:0])
                begin $error("key_0 exp %h got %h", exp_r.key[31:0], key_0); errors++; end
                if (key_1 !== exp_r.key[63:32])
                begin $error("key_1 exp %h got %h", exp_r.key[63:32], key_1); errors++; end
                if (key_2 !== exp_r.key[95:64])
                begin $error("key_2 exp %h got %h", exp_r.key[95:64], key_2); errors++; end
                if (key_3 !== exp_r.key[127:96])
                begin $error("key_3 exp %h got %h", exp_r.key[127:96], key_3); errors++; end
                if (used_default !== exp_r.used_default)
                begin
                    $error("used_default exp %b got %b", exp_r.used_default, used_default);
                    errors++;
                end
                if (need_rekey !== exp_r.need_rekey)
                begin
                    $error("need_rekey exp %b got %b", exp_r.need_rekey, need_rekey);
                    errors++;
                end
                if (status !== exp_r.status)
                begin $error("status exp %0d got %0d", exp_r.status, status); errors++; end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 7) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
    end

    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_valid = 0; action = 0; session_id = 0; now = 0;
        new_key_0 = 0; new_key_1 = 0; new_key_2 = 0; new_key_3 = 0;
        out_ready = 1'b1;
        m_dkey = {skt_pkg::DEF_KEY3_RST, skt_pkg::DEF_KEY2_RST,
                  skt_pkg::DEF_KEY1_RST, skt_pkg::DEF_KEY0_RST};
        m_rekey = skt_pkg::REKEY_AGE_RST;
        m_sweep = skt_pkg::SWEEP_INT_RST;
        m_expire = skt_pkg::EXPIRE_AGE_RST;
        m_last_sweep = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            m_valid[i] = 0; m_sid[i] = 0; m_key[i] = 0; m_stamp[i] = 0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_directed();
        test_config_extremes();
        test_random_settings();
        $display("Sent %0d items, checked %0d results over several register settings.",
                 n_items, n_replies);
        if (errors == 0 && reply_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
